// ===== rtl/rfagc_pkg.sv =====
package rfagc_pkg;

	localparam int CHANNELS_DEF = 4;
	localparam int ADDR_W       = 5;
	localparam int DATA_W       = 32;

	// dead band around the target level, in dB
	localparam int DEAD_BAND   = 1;
	// slide credit loaded into both directions at set-up
	localparam int SLIDE_START = 100;

	// register reset values
	localparam logic [6:0] RF_ATT_MAX_RST  = 7'd30;
	localparam logic [6:0] MGC_ATT_MAX_RST = 7'd30;

	typedef enum logic [2:0] {
		REG_GAIN_MODE     = 3'd0,
		REG_TARGET_LEVEL  = 3'd1,
		REG_STEP_INTERVAL = 3'd2,
		REG_RF_ATT_MIN    = 3'd3,
		REG_RF_ATT_MAX    = 3'd4,
		REG_MGC_ATT_MIN   = 3'd5,
		REG_MGC_ATT_MAX   = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_MANUAL  = 3'd0,
		ST_WAITING = 3'd1,
		ST_IN_BAND = 3'd2,
		ST_LOWERED = 3'd3,
		ST_RAISED  = 3'd4,
		ST_TOP     = 3'd5,
		ST_BOTTOM  = 3'd6
	} agc_status_t;

endpackage

// ===== rtl/rf_agc_attenuation_stepper.sv =====
// Stepped automatic gain control for up to CHANNELS receiver channels. Each
// item carries a channel, the ticks since that channel's previous item and the
// measured level in dB; each item gives exactly one result with the channel's
// status and its rf and digital (mgc) attenuation, plus write strobes telling
// software which attenuation to push to the front end. The block takes one
// item per clock while the output is not stalled: an input register holds
// the item while the per-channel state is read, updated and written back,
// and an output register holds the result; the next item (even for the same
// channel) may enter the input register as the previous one leaves it.
// in_ready only drops while a result waits in the output register and the
// input register is also full. Settings are written over the APB-style port
// at byte address 4*index and are shared by all channels; any write to a
// known register restarts the set-up of every channel. Write settings only
// while no item is in flight.
module rf_agc_attenuation_stepper #(
	parameter int CHANNELS = rfagc_pkg::CHANNELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rfagc_pkg::ADDR_W-1:0] paddr,
	input  logic [rfagc_pkg::DATA_W-1:0] pwdata,
	output logic [rfagc_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	// item input
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   channel,
	input  logic [15:0]                  elapsed_ticks,
	input  logic signed [7:0]            level_db,
	// result output
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   out_channel,
	output logic [2:0]                   status,
	output logic [6:0]                   rf_att,
	output logic [6:0]                   mgc_att,
	output logic                         rf_write,
	output logic                         mgc_write
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic signed [9:0] BAND_W = 10'(rfagc_pkg::DEAD_BAND);
	localparam logic [7:0] SLIDE_W = 8'(rfagc_pkg::SLIDE_START);

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic                    gain_mode_q;
	logic signed [7:0]       target_level_q;
	logic [15:0]             step_interval_q;
	logic [6:0]              rf_att_min_q;
	logic [6:0]              rf_att_max_q;
	logic [6:0]              mgc_att_min_q;
	logic [6:0]              mgc_att_max_q;

	rfagc_pkg::reg_idx_t     reg_idx;
	logic                    cfg_wr;
	logic                    cfg_hit;

	assign pready  = 1'b1;
	assign reg_idx = rfagc_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel & penable & pwrite;

	// a write to an unknown address does nothing, not even a set-up restart
	always_comb begin
		case (reg_idx)
			rfagc_pkg::REG_GAIN_MODE,
			rfagc_pkg::REG_TARGET_LEVEL,
			rfagc_pkg::REG_STEP_INTERVAL,
			rfagc_pkg::REG_RF_ATT_MIN,
			rfagc_pkg::REG_RF_ATT_MAX,
			rfagc_pkg::REG_MGC_ATT_MIN,
			rfagc_pkg::REG_MGC_ATT_MAX: cfg_hit = 1'b1;
			default:                    cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_mode_q     <= 1'b0;
			target_level_q  <= '0;
			step_interval_q <= '0;
			rf_att_min_q    <= '0;
			rf_att_max_q    <= rfagc_pkg::RF_ATT_MAX_RST;
			mgc_att_min_q   <= '0;
			mgc_att_max_q   <= rfagc_pkg::MGC_ATT_MAX_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				rfagc_pkg::REG_GAIN_MODE:     gain_mode_q     <= pwdata[0];
				rfagc_pkg::REG_TARGET_LEVEL:  target_level_q  <= pwdata[7:0];
				rfagc_pkg::REG_STEP_INTERVAL: step_interval_q <= pwdata[15:0];
				rfagc_pkg::REG_RF_ATT_MIN:    rf_att_min_q    <= pwdata[6:0];
				rfagc_pkg::REG_RF_ATT_MAX:    rf_att_max_q    <= pwdata[6:0];
				rfagc_pkg::REG_MGC_ATT_MIN:   mgc_att_min_q   <= pwdata[6:0];
				rfagc_pkg::REG_MGC_ATT_MAX:   mgc_att_max_q   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// register readback, zero extended
	always_comb begin
		case (reg_idx)
			rfagc_pkg::REG_GAIN_MODE:     prdata = 32'(gain_mode_q);
			rfagc_pkg::REG_TARGET_LEVEL:  prdata = 32'(unsigned'(target_level_q));
			rfagc_pkg::REG_STEP_INTERVAL: prdata = 32'(step_interval_q);
			rfagc_pkg::REG_RF_ATT_MIN:    prdata = 32'(rf_att_min_q);
			rfagc_pkg::REG_RF_ATT_MAX:    prdata = 32'(rf_att_max_q);
			rfagc_pkg::REG_MGC_ATT_MIN:   prdata = 32'(mgc_att_min_q);
			rfagc_pkg::REG_MGC_ATT_MAX:   prdata = 32'(mgc_att_max_q);
			default:                      prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// pipeline control: input register (s1) and result register (s2)
	// ---------------------------------------------------------------
	logic                vld_s1;
	logic [1:0]          ch_s1;
	logic [15:0]         ticks_s1;
	logic signed [7:0]   level_s1;

	logic                vld_s2;
	logic [1:0]          ch_s2;
	rfagc_pkg::agc_status_t status_s2;
	logic [6:0]          rf_s2;
	logic [6:0]          mgc_s2;
	logic                rfw_s2;
	logic                mgw_s2;

	logic                adv;     // s1 item moves into the result register

	assign adv      = vld_s1 & (~vld_s2 | out_ready);
	assign in_ready = ~vld_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1    <= channel;
			ticks_s1 <= elapsed_ticks;
			level_s1 <= level_db;
		end
	end

	// ---------------------------------------------------------------
	// per-channel state
	// ---------------------------------------------------------------
	logic [CHANNELS-1:0] setup_pend_q;
	logic [CHANNELS-1:0] timer_run_q;
	logic [15:0]         accum_q [CHANNELS];
	logic [6:0]          rf_now_q [CHANNELS];
	logic [6:0]          mgc_now_q [CHANNELS];
	logic [7:0]          up_cred_q [CHANNELS];
	logic [7:0]          dn_cred_q [CHANNELS];

	logic [IDX_W-1:0]    idx;
	logic                ch_ok;

	assign idx   = IDX_W'(ch_s1);
	assign ch_ok = 32'(ch_s1) < CHANNELS;

	// ---------------------------------------------------------------
	// control step for the item in s1
	// ---------------------------------------------------------------
	logic                auto_on;
	logic                setup;
	logic [7:0]          mix_sum;
	logic [6:0]          half;
	logic [6:0]          mgc_setup;
	logic [6:0]          rf0, mgc0;
	logic [7:0]          up0, dn0;
	logic [16:0]         acc_sum;
	logic [15:0]         acc1;
	logic signed [9:0]   lvl_w, tgt_w;
	logic                go_lower, go_raise;

	logic [15:0]         acc_n;
	logic [6:0]          rf_n, mgc_n;
	logic [7:0]          up_n, dn_n;
	logic                rfw, mgw;
	rfagc_pkg::agc_status_t stat;

	assign auto_on = gain_mode_q;
	assign setup   = auto_on & setup_pend_q[idx];

	// set-up mgc point: half of (rf_max + mgc_max) above rf_max, floored at 0
	assign mix_sum   = {1'b0, rf_att_max_q} + {1'b0, mgc_att_max_q};
	assign half      = mix_sum[7:1];
	assign mgc_setup = (half > rf_att_max_q) ? (half - rf_att_max_q) : '0;

	assign rf0  = setup ? rf_att_max_q : rf_now_q[idx];
	assign mgc0 = setup ? mgc_setup    : mgc_now_q[idx];
	assign up0  = setup ? SLIDE_W      : up_cred_q[idx];
	assign dn0  = setup ? SLIDE_W      : dn_cred_q[idx];

	// timer: saturating accumulate once running; first auto item only arms it
	assign acc_sum = {1'b0, accum_q[idx]} + {1'b0, ticks_s1};
	always_comb begin
		if (timer_run_q[idx]) begin
			acc1 = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
		end else if (auto_on) begin
			acc1 = '0;
		end else begin
			acc1 = accum_q[idx];
		end
	end

	assign lvl_w    = 10'(level_s1);
	assign tgt_w    = 10'(target_level_q);
	assign go_lower = lvl_w < (tgt_w - BAND_W);
	assign go_raise = lvl_w > (tgt_w + BAND_W);

	always_comb begin
		acc_n = acc1;
		rf_n  = rf0;
		mgc_n = mgc0;
		up_n  = up0;
		dn_n  = dn0;
		rfw   = setup;
		mgw   = setup;
		stat  = rfagc_pkg::ST_MANUAL;
		if (auto_on) begin
			if (acc1 < step_interval_q) begin
				stat = rfagc_pkg::ST_WAITING;
			end else begin
				acc_n = '0;
				if (go_lower) begin
					if (up0 == '0) begin
						stat = rfagc_pkg::ST_TOP;
					end else begin
						up_n = up0 - 8'd1;
						if (dn0 != 8'hFF) begin
							dn_n = dn0 + 8'd1;
						end
						// rf stage first, then mgc
						if (rf0 > rf_att_min_q) begin
							rf_n = rf0 - 7'd1;
							rfw  = 1'b1;
						end else if (mgc0 > mgc_att_min_q) begin
							mgc_n = mgc0 - 7'd1;
							mgw   = 1'b1;
						end
						stat = rfagc_pkg::ST_LOWERED;
					end
				end else if (go_raise) begin
					if (dn0 == '0) begin
						stat = rfagc_pkg::ST_BOTTOM;
					end else begin
						dn_n = dn0 - 8'd1;
						if (up0 != 8'hFF) begin
							up_n = up0 + 8'd1;
						end
						if (rf0 < rf_att_max_q) begin
							rf_n = rf0 + 7'd1;
							rfw  = 1'b1;
						end else if (mgc0 < mgc_att_max_q) begin
							mgc_n = mgc0 + 7'd1;
							mgw   = 1'b1;
						end
						stat = rfagc_pkg::ST_RAISED;
					end
				end else begin
					stat = rfagc_pkg::ST_IN_BAND;
				end
			end
		end
	end

	// state write-back as the item leaves s1; a write to a known register re-arms set-up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_pend_q <= '1;
			timer_run_q  <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				accum_q[i]   <= '0;
				rf_now_q[i]  <= '0;
				mgc_now_q[i] <= '0;
				up_cred_q[i] <= '0;
				dn_cred_q[i] <= '0;
			end
		end else begin
			if (adv && ch_ok) begin
				timer_run_q[idx] <= timer_run_q[idx] | auto_on;
				accum_q[idx]     <= acc_n;
				rf_now_q[idx]    <= rf_n;
				mgc_now_q[idx]   <= mgc_n;
				up_cred_q[idx]   <= up_n;
				dn_cred_q[idx]   <= dn_n;
			end
			if (cfg_wr && cfg_hit) begin
				setup_pend_q <= '1;
			end else if (adv && ch_ok && setup) begin
				setup_pend_q[idx] <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (~vld_s2 | out_ready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s2 <= ch_s1;
			if (ch_ok) begin
				status_s2 <= stat;
				rf_s2     <= rf_n;
				mgc_s2    <= mgc_n;
				rfw_s2    <= rfw;
				mgw_s2    <= mgw;
			end else begin
				// channel not fitted: answer manual with everything zero
				status_s2 <= rfagc_pkg::ST_MANUAL;
				rf_s2     <= '0;
				mgc_s2    <= '0;
				rfw_s2    <= 1'b0;
				mgw_s2    <= 1'b0;
			end
		end
	end

	assign out_valid   = vld_s2;
	assign out_channel = ch_s2;
	assign status      = status_s2;
	assign rf_att      = rf_s2;
	assign mgc_att     = mgc_s2;
	assign rf_write    = rfw_s2;
	assign mgc_write   = mgw_s2;

endmodule

// ===== rtl/rfagc_checker.sv =====
module rfagc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_channel,
	input logic [2:0] status,
	input logic [6:0] rf_att,
	input logic [6:0] mgc_att,
	input logic       rf_write,
	input logic       mgc_write
);

	// a stalled item holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(status)
			&& $stable(rf_att) && $stable(mgc_att) && $stable(rf_write)
			&& $stable(mgc_write))
		else $error("result changed while stalled");

	// with the result register empty nothing can hold back the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// manual items never request a front-end write
	a_manual_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rfagc_pkg::ST_MANUAL |-> !rf_write && !mgc_write)
		else $error("write strobe in manual mode");

	// a saturated slide never moves either stage
	a_limit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == rfagc_pkg::ST_TOP || status == rfagc_pkg::ST_BOTTOM)
			|-> !rf_write && !mgc_write)
		else $error("write strobe at slide limit");

	// status is always one of the defined codes
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= rfagc_pkg::ST_BOTTOM)
		else $error("undefined status code");

endmodule

bind rf_agc_attenuation_stepper rfagc_checker u_rfagc_checker (.*);

// ===== tb/testbench.sv =====
module testbench;

	localparam int NUM_CH    = rfagc_pkg::CHANNELS_DEF;
	// first register index past the end of the map, writes there must be ignored
	localparam int REG_SPARE = 7;
	// chance in percent that a side idles in a given cycle
	localparam int IDLE_PCT  = 8;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [rfagc_pkg::ADDR_W-1:0]    paddr;
	logic [rfagc_pkg::DATA_W-1:0]    pwdata;
	logic [rfagc_pkg::DATA_W-1:0]    prdata;
	logic                            pready;
	logic                            in_valid;
	logic                            in_ready;
	logic [1:0]                      channel;
	logic [15:0]                     elapsed_ticks;
	logic signed [7:0]               level_db;
	logic                            out_valid;
	logic                            out_ready;
	logic [1:0]                      out_channel;
	logic [2:0]                      status;
	logic [6:0]                      rf_att;
	logic [6:0]                      mgc_att;
	logic                            rf_write;
	logic                            mgc_write;

	// one expected result of the block
	typedef struct packed {
		logic [1:0]             ch;
		rfagc_pkg::agc_status_t st;
		logic [6:0]             rf;
		logic [6:0]             mgc;
		logic                   rfw;
		logic                   mgw;
	} agc_result_t;

	agc_result_t expected_results[$];
	int          mismatches;
	// when set neither side idles
	bit          steady;

	// shadow copy of the shared settings
	logic              cfg_mode;
	logic signed [7:0] cfg_target;
	logic [15:0]       cfg_interval;
	logic [6:0]        cfg_rf_min;
	logic [6:0]        cfg_rf_max;
	logic [6:0]        cfg_mgc_min;
	logic [6:0]        cfg_mgc_max;

	// shadow copy of the per-channel control state
	logic        setup_pend[NUM_CH];
	logic        timer_on[NUM_CH];
	logic [15:0] accum[NUM_CH];
	logic [6:0]  rf_now[NUM_CH];
	logic [6:0]  mgc_now[NUM_CH];
	logic [7:0]  credit_up[NUM_CH];
	logic [7:0]  credit_down[NUM_CH];

	rf_agc_attenuation_stepper u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.channel       (channel),
		.elapsed_ticks (elapsed_ticks),
		.level_db      (level_db),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_channel   (out_channel),
		.status        (status),
		.rf_att        (rf_att),
		.mgc_att       (mgc_att),
		.rf_write      (rf_write),
		.mgc_write     (mgc_write)
	);

	// 2 time unit clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case a handshake hangs
	initial begin
		#400000;
		$display("** rf_agc_attenuation_stepper: FAILED **");
		$finish;
	end

	// one control step of one channel, updates the shadow state and gives the result
	function automatic agc_result_t predict_agc_step(input logic [1:0] ch,
			input logic [15:0] ticks, input logic signed [7:0] level);
		agc_result_t r;
		int half;
		int sum;
		int lvl;
		int tgt;
		r.ch  = ch;
		r.st  = rfagc_pkg::ST_MANUAL;
		r.rfw = 1'b0;
		r.mgw = 1'b0;
		lvl   = level;
		tgt   = cfg_target;
		// first agc item after reset or a settings write loads the start point
		if (cfg_mode && setup_pend[ch]) begin
			half            = (int'(cfg_rf_max) + int'(cfg_mgc_max)) / 2;
			rf_now[ch]      = cfg_rf_max;
			mgc_now[ch]     = (half > int'(cfg_rf_max)) ? 7'(half - int'(cfg_rf_max)) : 7'd0;
			credit_up[ch]   = 8'(rfagc_pkg::SLIDE_START);
			credit_down[ch] = 8'(rfagc_pkg::SLIDE_START);
			setup_pend[ch]  = 1'b0;
			r.rfw           = 1'b1;
			r.mgw           = 1'b1;
		end
		// running timer accumulates in either mode, saturating
		if (timer_on[ch]) begin
			sum       = int'(accum[ch]) + int'(ticks);
			accum[ch] = (sum > 65535) ? 16'hffff : 16'(sum);
		end else if (cfg_mode) begin
			timer_on[ch] = 1'b1;
			accum[ch]    = 16'd0;
		end
		if (cfg_mode) begin
			if (accum[ch] < cfg_interval) begin
				r.st = rfagc_pkg::ST_WAITING;
			end else begin
				accum[ch] = 16'd0;
				if (lvl < tgt - rfagc_pkg::DEAD_BAND) begin
					if (credit_up[ch] == 8'd0) begin
						r.st = rfagc_pkg::ST_TOP;
					end else begin
						credit_up[ch]--;
						if (credit_down[ch] != 8'hff) credit_down[ch]++;
						if (rf_now[ch] > cfg_rf_min) begin
							rf_now[ch]--;
							r.rfw = 1'b1;
						end else if (mgc_now[ch] > cfg_mgc_min) begin
							mgc_now[ch]--;
							r.mgw = 1'b1;
						end
						r.st = rfagc_pkg::ST_LOWERED;
					end
				end else if (lvl > tgt + rfagc_pkg::DEAD_BAND) begin
					if (credit_down[ch] == 8'd0) begin
						r.st = rfagc_pkg::ST_BOTTOM;
					end else begin
						credit_down[ch]--;
						if (credit_up[ch] != 8'hff) credit_up[ch]++;
						if (rf_now[ch] < cfg_rf_max) begin
							rf_now[ch]++;
							r.rfw = 1'b1;
						end else if (mgc_now[ch] < cfg_mgc_max) begin
							mgc_now[ch]++;
							r.mgw = 1'b1;
						end
						r.st = rfagc_pkg::ST_RAISED;
					end
				end else begin
					r.st = rfagc_pkg::ST_IN_BAND;
				end
			end
		end
		r.rf  = rf_now[ch];
		r.mgc = mgc_now[ch];
		return r;
	endfunction

	// level below (-1), inside (0) or above (+1) the dead band around the target
	function automatic logic signed [7:0] pick_level(input int dir);
		int tgt;
		int lo;
		int hi;
		tgt = cfg_target;
		case (dir)
			-1: begin
				lo = -128;
				hi = tgt - rfagc_pkg::DEAD_BAND - 1;
			end
			1: begin
				lo = tgt + rfagc_pkg::DEAD_BAND + 1;
				hi = 127;
			end
			default: begin
				lo = tgt - rfagc_pkg::DEAD_BAND;
				hi = tgt + rfagc_pkg::DEAD_BAND;
			end
		endcase
		// clip to the field, an empty side collapses onto the nearest edge
		if (lo < -128) lo = -128;
		if (lo > 127) lo = 127;
		if (hi < -128) hi = -128;
		if (hi > 127) hi = 127;
		if (hi < lo) hi = lo;
		return 8'(lo + int'($urandom_range(hi - lo)));
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// receiver side, random stalls unless in a steady stretch
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// results are checked against the oldest expectation, accepted items are predicted
	always @(posedge clk) begin : check_results
		agc_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result on channel %0d", out_channel));
				end else begin
					want = expected_results.pop_front();
					if (out_channel !== want.ch)
						report_mismatch($sformatf("out_channel %0d, want %0d",
							out_channel, want.ch));
					if (status !== want.st)
						report_mismatch($sformatf("ch %0d status %0d, want %0d",
							want.ch, status, want.st));
					if (rf_att !== want.rf)
						report_mismatch($sformatf("ch %0d rf_att %0d, want %0d",
							want.ch, rf_att, want.rf));
					if (mgc_att !== want.mgc)
						report_mismatch($sformatf("ch %0d mgc_att %0d, want %0d",
							want.ch, mgc_att, want.mgc));
					if (rf_write !== want.rfw)
						report_mismatch($sformatf("ch %0d rf_write %0b, want %0b",
							want.ch, rf_write, want.rfw));
					if (mgc_write !== want.mgw)
						report_mismatch($sformatf("ch %0d mgc_write %0b, want %0b",
							want.ch, mgc_write, want.mgw));
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(predict_agc_step(channel, elapsed_ticks, level_db));
		end
	end

	// one item, with a random gap in front of it; returns right after the accepting edge
	task automatic send_item(input logic [1:0] ch, input logic [15:0] ticks,
			input logic signed [7:0] level);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		channel       <= ch;
		elapsed_ticks <= ticks;
		level_db      <= level;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop sending and wait for every outstanding result
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// block idle before touching settings, plus the pipeline depth for good measure
	task automatic settle_for_config();
		wait_drained();
		repeat (3) @(posedge clk);
	endtask

	// apb write, random junk above the field to check it is masked off
	task automatic reg_write(input int idx, input logic [31:0] val);
		logic [31:0] mask;
		int c;
		case (idx)
			rfagc_pkg::REG_GAIN_MODE:     mask = 32'h1;
			rfagc_pkg::REG_TARGET_LEVEL:  mask = 32'hff;
			rfagc_pkg::REG_STEP_INTERVAL: mask = 32'hffff;
			rfagc_pkg::REG_RF_ATT_MIN, rfagc_pkg::REG_RF_ATT_MAX,
			rfagc_pkg::REG_MGC_ATT_MIN, rfagc_pkg::REG_MGC_ATT_MAX: mask = 32'h7f;
			default:                      mask = 32'h0;
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= rfagc_pkg::ADDR_W'(idx * 4);
		pwdata  <= ($urandom & ~mask) | (val & mask);
		@(posedge clk);
		penable <= 1'b1;
		// register takes the value at this edge
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			rfagc_pkg::REG_GAIN_MODE:     cfg_mode     = val[0];
			rfagc_pkg::REG_TARGET_LEVEL:  cfg_target   = val[7:0];
			rfagc_pkg::REG_STEP_INTERVAL: cfg_interval = val[15:0];
			rfagc_pkg::REG_RF_ATT_MIN:    cfg_rf_min   = val[6:0];
			rfagc_pkg::REG_RF_ATT_MAX:    cfg_rf_max   = val[6:0];
			rfagc_pkg::REG_MGC_ATT_MIN:   cfg_mgc_min  = val[6:0];
			rfagc_pkg::REG_MGC_ATT_MAX:   cfg_mgc_max  = val[6:0];
			default: ;
		endcase
		// any known register restarts the set-up of every channel
		if (mask != 32'h0)
			for (c = 0; c < NUM_CH; c++) setup_pend[c] = 1'b1;
		@(posedge clk);
	endtask

	task automatic apply_settings(input int mode, input int target, input int interval,
			input int rmin, input int rmax, input int mmin, input int mmax);
		settle_for_config();
		reg_write(rfagc_pkg::REG_GAIN_MODE, mode);
		reg_write(rfagc_pkg::REG_TARGET_LEVEL, target);
		reg_write(rfagc_pkg::REG_STEP_INTERVAL, interval);
		reg_write(rfagc_pkg::REG_RF_ATT_MIN, rmin);
		reg_write(rfagc_pkg::REG_RF_ATT_MAX, rmax);
		reg_write(rfagc_pkg::REG_MGC_ATT_MIN, mmin);
		reg_write(rfagc_pkg::REG_MGC_ATT_MAX, mmax);
	endtask

	// out of reset the block is in manual mode: no control, timer not started
	task automatic test_manual_after_reset();
		send_item(2'd0, 16'h0000, -8'sd128);
		send_item(2'd1, 16'hffff, 8'sd127);
		send_item(2'd2, 16'h5555, 8'sd0);
		send_item(2'd3, 16'haaaa, -8'sd1);
	endtask

	// first agc item of each channel loads the start point, then steps around the band
	task automatic test_agc_setup();
		settle_for_config();
		reg_write(rfagc_pkg::REG_GAIN_MODE, 1);
		send_item(2'd0, 16'd0, 8'sd0);
		send_item(2'd1, 16'd1, -8'sd2);
		send_item(2'd2, 16'd2, 8'sd2);
		send_item(2'd3, 16'd3, -8'sd1);
		send_item(2'd0, 16'd100, 8'sd1);
		send_item(2'd0, 16'd0, -8'sd128);
		send_item(2'd0, 16'hffff, 8'sd127);
	endtask

	// decisions wait for the step interval, accumulated time saturates
	task automatic test_step_timer();
		settle_for_config();
		reg_write(rfagc_pkg::REG_STEP_INTERVAL, 10);
		send_item(2'd0, 16'd3, -8'sd5);
		send_item(2'd0, 16'd6, -8'sd5);
		send_item(2'd0, 16'd1, -8'sd5);
		settle_for_config();
		reg_write(rfagc_pkg::REG_STEP_INTERVAL, 65535);
		send_item(2'd1, 16'd40000, -8'sd5);
		// would wrap below the interval without saturation
		send_item(2'd1, 16'd40000, -8'sd5);
	endtask

	// a write past the register map must not restart the set-up
	task automatic test_unmapped_register();
		send_item(2'd2, 16'd0, 8'sd0);
		settle_for_config();
		reg_write(REG_SPARE, $urandom);
		send_item(2'd2, 16'd0, 8'sd0);
	endtask

	// push one channel down and one up until the slide credit runs out, no idling here
	task automatic test_slide_limits();
		int k;
		int pick;
		logic [1:0] ch;
		logic signed [7:0] level;
		steady = 1'b1;
		apply_settings(1, 0, 0, 0, 30, 0, 30);
		for (k = 0; k < 260; k++) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				ch    = 2'd0;
				level = pick_level(-1);
			end else if (pick < 90) begin
				ch    = 2'd1;
				level = pick_level(1);
			end else begin
				ch    = 2'(2 + $urandom_range(1));
				level = pick_level(int'($urandom_range(2)) - 1);
			end
			send_item(ch, 16'($urandom_range(20)), level);
		end
		wait_drained();
		steady = 1'b0;
	endtask

	// several settings, extremes first, each channel following a drifting level trend
	task automatic test_random_phases();
		int phase;
		int k;
		int mode;
		int tgt;
		int ivl;
		int rmin;
		int rmax;
		int mmin;
		int mmax;
		int trend[NUM_CH];
		logic [1:0] ch;
		logic [15:0] ticks;
		logic signed [7:0] level;
		for (phase = 0; phase < 6; phase++) begin
			mode = 1;
			tgt  = int'($urandom_range(60)) - 30;
			ivl  = $urandom_range(4);
			rmin = $urandom_range(20);
			rmax = $urandom_range(127);
			mmin = $urandom_range(20);
			mmax = $urandom_range(127);
			case (phase)
				0: begin
					tgt  = -128;
					ivl  = 0;
					rmin = 0;
					rmax = 127;
					mmin = 0;
					mmax = 127;
				end
				// bounds crossed over and the longest interval
				1: begin
					tgt  = 127;
					ivl  = 65535;
					rmin = 127;
					rmax = 0;
					mmin = 127;
					mmax = 0;
				end
				// manual: only the timers keep counting
				2: mode = 0;
				default: ;
			endcase
			apply_settings(mode, tgt, ivl, rmin, rmax, mmin, mmax);
			for (k = 0; k < NUM_CH; k++) trend[k] = $urandom_range(1) ? 1 : -1;
			for (k = 0; k < 45; k++) begin
				// sender holds off once per phase until the block has drained
				if (k == 22) wait_drained();
				ch = 2'($urandom_range(3));
				if ($urandom_range(99) < 5) trend[ch] = int'($urandom_range(2)) - 1;
				if ($urandom_range(99) < 70)
					level = pick_level(trend[ch]);
				else
					level = 8'($urandom);
				if (cfg_interval > 16'd1000 || $urandom_range(99) < 10)
					ticks = 16'($urandom);
				else
					ticks = 16'($urandom_range(int'(cfg_interval) + 2));
				send_item(ch, ticks, level);
			end
		end
	endtask

	initial begin
		int c;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		channel       = 2'd0;
		elapsed_ticks = 16'd0;
		level_db      = 8'sd0;
		out_ready     = 1'b0;
		mismatches    = 0;
		steady        = 1'b0;
		// predictor starts from the reset values
		cfg_mode      = 1'b0;
		cfg_target    = 8'sd0;
		cfg_interval  = 16'd0;
		cfg_rf_min    = 7'd0;
		cfg_rf_max    = rfagc_pkg::RF_ATT_MAX_RST;
		cfg_mgc_min   = 7'd0;
		cfg_mgc_max   = rfagc_pkg::MGC_ATT_MAX_RST;
		for (c = 0; c < NUM_CH; c++) begin
			setup_pend[c]  = 1'b1;
			timer_on[c]    = 1'b0;
			accum[c]       = 16'd0;
			rf_now[c]      = 7'd0;
			mgc_now[c]     = 7'd0;
			credit_up[c]   = 8'd0;
			credit_down[c] = 8'd0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_manual_after_reset();
		test_agc_setup();
		test_step_timer();
		test_unmapped_register();
		test_slide_limits();
		test_random_phases();

		// drain, then give any stray result time to show up
		wait_drained();
		repeat (6) @(posedge clk);
		if (mismatches == 0) begin
			$display("** rf_agc_attenuation_stepper: PASSED **");
		end else begin
			$display("** rf_agc_attenuation_stepper: FAILED **");
		end
		$finish;
	end

endmodule
